// ===== design/spectrum_bin_peak_decay_top_defines.svh =====
// Assertion macros for the checker file of the spectrum bin peak decay block.
`ifndef SPECTRUM_BIN_PEAK_DECAY_TOP_DEFINES_SVH
`define SPECTRUM_BIN_PEAK_DECAY_TOP_DEFINES_SVH

// Concurrent assertion on clk that is switched off while rst_n is low.
`define SBPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that is also checked during reset.
`define SBPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sbpd_pkg.sv =====
// Package with the shared types, constants and the bin edge function of the peak decay block.
package sbpd_pkg;

    // Fixed field widths of the streams.
    localparam int unsigned MAG_W    = 16;
    localparam int unsigned BNUM_W   = 5;
    localparam int unsigned OUT_W    = 24;
    localparam logic [MAG_W-1:0] DECAY_RESET = 16'd655;

    // Width of the exact big-number arithmetic used to build the edge table.
    localparam int unsigned BIG_W = 4104;

    // Close request handed from the bin tracker to the level update.
    typedef struct packed {
        logic              valid;
        logic [BNUM_W-1:0] bin_number;
        logic [MAG_W-1:0]  max_level;
        logic              last;
        logic              load;
    } close_req_t;

    // Largest n <= cap with n^b <= m^a, where a/b is the reduced exponent ex_q8/256.
    function automatic int unsigned edge_calc(int unsigned m, int unsigned ex_q8,
                                              int unsigned cap);
        logic [BIG_W-1:0]    pm;
        logic [BIG_W-1:0]    pn;
        logic [BIG_W+16:0]   wide;
        int unsigned         ex;
        int unsigned         a;
        int unsigned         b;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         mid;
        int unsigned         k;
        bit                  sat;
        ex = ex_q8;
        if (ex < 256) ex = 256;
        if (ex > 1024) ex = 1024;
        a = ex;
        b = 256;
        // The denominator is a power of two, so the common factor is shifted out.
        while (a[0] == 1'b0 && b > 1)
        begin
            a = a >> 1;
            b = b >> 1;
        end
        // m^a, saturating: a saturated value exceeds every n^b that can occur.
        pm  = BIG_W'(1);
        sat = 1'b0;
        for (k = 0; k < a && !sat; k++)
        begin
            wide = {17'd0, pm} * (BIG_W+17)'(m);
            if (wide[BIG_W+16:BIG_W] != 17'd0) sat = 1'b1;
            pm = wide[BIG_W-1:0];
        end
        // Binary search for the edge.
        lo = 0;
        hi = cap;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo + 1) >> 1);
            pn  = BIG_W'(1);
            for (k = 0; k < b; k++)
            begin
                pn = pn * BIG_W'(mid);
            end
            if (sat || pn <= pm) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

endpackage

// ===== design/sbpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module sbpd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, and registered read port (old data on a collision).
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sbpd_bin_track.sv =====
// Bin tracker: sample position, open bin, running maximum and bin close detection.
module sbpd_bin_track
    import sbpd_pkg::*;
#(
    parameter int unsigned NUM_BINS     = 32,
    parameter int unsigned START_OFFSET = 1,
    parameter int unsigned EXPONENT_Q8  = 512,
    parameter int unsigned BLOCK_LENGTH = 2048
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         accept,
    input  logic [MAG_W-1:0]                             magnitude,
    input  logic                                         block_end,
    output close_req_t                                   req,
    output logic [(NUM_BINS > 1 ? $clog2(NUM_BINS) : 1)-1:0] req_addr
);

    localparam int unsigned AW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int unsigned BW  = $clog2(NUM_BINS + 1);
    localparam int unsigned PW  = $clog2(BLOCK_LENGTH + 1);
    localparam int unsigned CAP = (BLOCK_LENGTH > START_OFFSET) ?
                                  (BLOCK_LENGTH - START_OFFSET) : 0;

    logic [PW-1:0]    edge_tab [NUM_BINS];
    logic [PW-1:0]    pos_reg;
    logic [PW-1:0]    pos_next;
    logic [BW-1:0]    bin_reg;
    logic [BW-1:0]    bin_next;
    logic [MAG_W-1:0] max_reg;
    logic [MAG_W-1:0] max_next;
    logic             primed_reg;
    logic             primed_next;
    logic             in_range;
    logic [PW-1:0]    rel;
    logic [MAG_W-1:0] mx;
    logic             hit;
    logic             close;
    logic             is_last;

    // Constant bin edge table, built at elaboration.
    for (genvar g = 0; g < NUM_BINS; g++)
    begin : g_edge
        localparam int unsigned EDGE_V = edge_calc(g + 1, EXPONENT_Q8, CAP);
        assign edge_tab[g] = PW'(EDGE_V);
    end

    // Close detection for the sample at hand.
    always_comb
    begin
        in_range = ({1'b0, pos_reg} >= (PW+1)'(START_OFFSET)) &&
                   (pos_reg < PW'(BLOCK_LENGTH)) &&
                   (bin_reg < BW'(NUM_BINS));
        rel      = pos_reg - PW'(START_OFFSET);
        mx       = (magnitude > max_reg) ? magnitude : max_reg;
        hit      = (({1'b0, rel} + (PW+1)'(1)) == {1'b0, edge_tab[bin_reg[AW-1:0]]});
        close    = accept && in_range && hit;
        is_last  = (bin_reg == BW'(NUM_BINS - 1));
    end

    // Close request toward the level update.
    always_comb
    begin
        req.valid      = close;
        req.bin_number = BNUM_W'(bin_reg);
        req.max_level  = mx;
        req.last       = is_last;
        req.load       = !primed_reg;
        req_addr       = bin_reg[AW-1:0];
    end

    // Next state of the position counter, open bin, running maximum and priming flag.
    always_comb
    begin
        pos_next    = pos_reg;
        bin_next    = bin_reg;
        max_next    = max_reg;
        primed_next = primed_reg;
        if (accept)
        begin
            if (in_range)
            begin
                if (hit)
                begin
                    max_next = '0;
                    bin_next = bin_reg + BW'(1);
                    if (is_last)
                    begin
                        primed_next = 1'b1;
                    end
                end
                else
                begin
                    max_next = mx;
                end
            end
            if (block_end)
            begin
                pos_next = '0;
                bin_next = '0;
                max_next = '0;
            end
            else if (pos_reg < PW'(BLOCK_LENGTH))
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            bin_reg    <= '0;
            max_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            bin_reg    <= bin_next;
            max_reg    <= max_next;
            primed_reg <= primed_next;
        end
    end

endmodule

// ===== design/sbpd_level_upd.sv =====
// Level update: reads the held level, applies the decay limit, writes back and registers the item.
module sbpd_level_upd
    import sbpd_pkg::*;
#(
    parameter int unsigned NUM_BINS = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_wr_en,
    input  logic [MAG_W-1:0]                             cfg_wr_data,
    input  close_req_t                                   req,
    input  logic [(NUM_BINS > 1 ? $clog2(NUM_BINS) : 1)-1:0] req_addr,
    output logic                                         take,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [BNUM_W-1:0]                            out_bin,
    output logic [MAG_W-1:0]                             out_level,
    output logic                                         out_last
);

    localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    logic [MAG_W-1:0]  decay_reg;
    logic              s1_valid_reg;
    close_req_t        s1_req_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              s1_byp_reg;
    logic [MAG_W-1:0]  s1_byp_data_reg;
    logic              out_valid_reg;
    logic [BNUM_W-1:0] out_bin_reg;
    logic [MAG_W-1:0]  out_level_reg;
    logic              out_last_reg;
    logic [MAG_W-1:0]  rd_data;
    logic [MAG_W-1:0]  old_level;
    logic [MAG_W-1:0]  new_level;
    logic [MAG_W-1:0]  fall;
    logic              s1_adv;
    logic              wr_en;
    logic              byp_hit;

    // Held levels, one entry per bin.
    sbpd_ram #(
        .WIDTH (MAG_W),
        .DEPTH (NUM_BINS)
    ) u_levels (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (new_level),
        .re    (req.valid),
        .raddr (req_addr),
        .rdata (rd_data)
    );

    // Handshake between the read stage and the output register.
    always_comb
    begin
        s1_adv  = !out_valid_reg || out_ready;
        take    = !s1_valid_reg || s1_adv;
        wr_en   = s1_valid_reg && s1_adv;
        byp_hit = wr_en && req.valid && (s1_addr_reg == req_addr);
    end

    // New held level: a load or a rise is taken at once, a fall is limited to the decay step.
    always_comb
    begin
        old_level = s1_byp_reg ? s1_byp_data_reg : rd_data;
        fall      = old_level - s1_req_reg.max_level;
        if (s1_req_reg.load || s1_req_reg.max_level >= old_level)
        begin
            new_level = s1_req_reg.max_level;
        end
        else if (fall > decay_reg)
        begin
            new_level = old_level - decay_reg;
        end
        else
        begin
            new_level = s1_req_reg.max_level;
        end
    end

    // Control registers and the decay step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg     <= DECAY_RESET;
            s1_valid_reg  <= 1'b0;
            s1_byp_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                decay_reg <= cfg_wr_data;
            end
            if (take)
            begin
                s1_valid_reg <= req.valid;
                s1_byp_reg   <= byp_hit;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers of the read stage and the output.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_req_reg      <= req;
            s1_addr_reg     <= req_addr;
            s1_byp_data_reg <= new_level;
        end
        if (s1_adv)
        begin
            out_bin_reg   <= s1_req_reg.bin_number;
            out_level_reg <= new_level;
            out_last_reg  <= s1_req_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bin   = out_bin_reg;
    assign out_level = out_level_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== design/spectrum_bin_peak_decay_top.sv =====
// Top level of the spectrum bin peak decay block.
// Throughput: one item per cycle; s_axis_tready falls only while a result waits and one more is in flight.
// A sample that closes a bin gives its result on m_axis through the read stage register and the output register.
// The path holds one read of the level memory plus the decay compare; samples that close no bin give no result.
// Reset clears the position, open bin, running maximum, priming flag and the output valid at once.
// The level memory is not cleared: until the first full block, every closed bin loads its level directly.
module spectrum_bin_peak_decay_top
    import sbpd_pkg::*;
#(
    parameter int unsigned NUM_BINS     = 32,
    parameter int unsigned START_OFFSET = 1,
    parameter int unsigned EXPONENT_Q8  = 512,
    parameter int unsigned BLOCK_LENGTH = 2048
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [15:0] magnitude
    input  logic             s_axis_tlast,   // block_end
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // [4:0] bin_number, [20:5] held_level, [23:21] zero
    output logic             m_axis_tlast,   // last_bin
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data     // decay_step
);

    localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    close_req_t        req;
    logic [AW-1:0]     req_addr;
    logic              take;
    logic              accept;
    logic [BNUM_W-1:0] out_bin;
    logic [MAG_W-1:0]  out_level;

    assign s_axis_tready = take;
    assign accept        = s_axis_tvalid && take;

    // Position counting and bin close detection.
    sbpd_bin_track #(
        .NUM_BINS     (NUM_BINS),
        .START_OFFSET (START_OFFSET),
        .EXPONENT_Q8  (EXPONENT_Q8),
        .BLOCK_LENGTH (BLOCK_LENGTH)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .magnitude (s_axis_tdata),
        .block_end (s_axis_tlast),
        .req       (req),
        .req_addr  (req_addr)
    );

    // Held level read, decay and write back.
    sbpd_level_upd #(
        .NUM_BINS (NUM_BINS)
    ) u_level (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .req_addr    (req_addr),
        .take        (take),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_bin     (out_bin),
        .out_level   (out_level),
        .out_last    (m_axis_tlast)
    );

    // Output packing.
    assign m_axis_tdata = {3'b000, out_level, out_bin};

endmodule

// ===== design/sbpd_checker.sv =====
// Port-level checker of the spectrum bin peak decay block and its bind to the top level.
`include "spectrum_bin_peak_decay_top_defines.svh"

module sbpd_checker #(
    parameter int unsigned NUM_BINS = 32
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result item stays offered.
    `SBPD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

    // A stalled result item keeps its payload.
    `SBPD_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // The final bin of a block carries the last bin number.
    `SBPD_ASSERT(a_last_bin, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == 5'(NUM_BINS - 1), "last flag on wrong bin")

    // With the output empty the input side always takes an item.
    `SBPD_ASSERT_ALWAYS(a_ready_idle, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

    // No result is offered while in reset.
    `SBPD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_axis_tvalid, "result offered during reset")

endmodule

bind spectrum_bin_peak_decay_top sbpd_checker #(.NUM_BINS(NUM_BINS)) u_sbpd_checker (.*);
